[sv/rgb_led_blink_controller_assert.svh]
// Assertion macros for the RGB LED blink controller.
`ifndef RGB_LED_BLINK_CONTROLLER_ASSERT_SVH
`define RGB_LED_BLINK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define RLBC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rlbc assertion failed");

// Next-cycle implication, checked out of reset only.
`define RLBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rlbc assertion failed");

`endif

[sv/rlbc_pkg.sv]
// Shared types, codes and constants of the RGB LED blink controller.
package rlbc_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned MaskW   = 3;
  localparam int unsigned Q3W     = 15;  // 65535 / 3 fits in 15 bits
  localparam int unsigned Q11W    = 13;  // 65535 / 11 fits in 13 bits
  localparam int unsigned IndexW  = 2;

  // Reciprocals: floor(p * M >> S) equals floor(p / d) for every 16-bit p.
  localparam logic [15:0] Recip3  = 16'd43691;
  localparam int unsigned Shift3  = 17;
  localparam logic [15:0] Recip11 = 16'd47663;
  localparam int unsigned Shift11 = 19;

  localparam int unsigned PeriodReset = 1000;
  localparam logic [PeriodW-1:0] PERIOD_RESET = PeriodW'(PeriodReset);
  localparam logic [Q3W-1:0]     Q3_RESET     = Q3W'(PeriodReset / 3);
  localparam logic [Q11W-1:0]    Q11_RESET    = Q11W'(PeriodReset / 11);

  localparam logic [MaskW-1:0] MASK_NONE  = 3'b000;
  localparam logic [MaskW-1:0] MASK_GREEN = 3'b010;

  typedef enum logic [IndexW-1:0] {
    REG_FLASH_PERIOD = 2'd0,
    REG_FLASH_MODE   = 2'd1,
    REG_LED_COLOR    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MODE_STEADY        = 3'd0,
    MODE_HALF          = 3'd1,
    MODE_THIRD         = 3'd2,
    MODE_SIXTH         = 3'd3,
    MODE_ELEVENTH      = 3'd4,
    MODE_TWO_THIRDS    = 3'd5,
    MODE_FIVE_SIXTHS   = 3'd6,
    MODE_TEN_ELEVENTHS = 3'd7
  } flash_mode_e;

  // Settings seen by the blink core.
  typedef struct packed {
    logic        [MaskW-1:0]   color;
    flash_mode_e               mode;
    logic        [PeriodW-1:0] on_time;
    logic        [PeriodW-1:0] off_time;
  } cfg_t;

endpackage

[sv/rlbc_in_if.sv]
// Input item channel: one millisecond tick with its card-seen flag.
interface rlbc_in_if;
  logic valid;
  logic ready;
  logic card_seen;

  modport source (output valid, output card_seen, input ready);
  modport sink   (input valid, input card_seen, output ready);
endinterface

[sv/rlbc_out_if.sv]
// Result item channel: the three LED drive bits.
interface rlbc_out_if;
  logic valid;
  logic ready;
  logic red_on;
  logic green_on;
  logic blue_on;

  modport source (output valid, output red_on, output green_on, output blue_on, input ready);
  modport sink   (input valid, input red_on, input green_on, input blue_on, output ready);
endinterface

[sv/rlbc_cfg_if.sv]
// Configuration write channel: register index and write data.
interface rlbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[sv/rlbc_cfg_regs.sv]
// Configuration registers with period quotients and phase-time selection.
module rlbc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  rlbc_cfg_if.sink          cfg_ch_i,
  output rlbc_pkg::cfg_t    cfg_o
);
  import rlbc_pkg::*;

  logic [PeriodW-1:0] period_q;
  logic [Q3W-1:0]     q3_q;
  logic [Q11W-1:0]    q11_q;
  flash_mode_e        mode_q;
  logic [MaskW-1:0]   color_q;

  logic               wr_en;
  logic [31:0]        prod3;
  logic [31:0]        prod11;
  logic [Q3W-2:0]     q6;
  logic [PeriodW-1:0] t_half, t_third, t_sixth, t_elev, t_two3, t_five6, t_ten11;
  logic [PeriodW-1:0] on_time, off_time;

  assign cfg_ch_i.ready = 1'b1;
  assign wr_en          = cfg_ch_i.valid;

  // Quotients taken from the write data, so they are ready with the period.
  assign prod3  = 32'(cfg_ch_i.wdata) * 32'(Recip3);
  assign prod11 = 32'(cfg_ch_i.wdata) * 32'(Recip11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      q3_q     <= Q3_RESET;
      q11_q    <= Q11_RESET;
      mode_q   <= MODE_STEADY;
      color_q  <= MASK_NONE;
    end else if (wr_en) begin
      unique case (cfg_reg_e'(cfg_ch_i.index))
        REG_FLASH_PERIOD: begin
          period_q <= cfg_ch_i.wdata;
          q3_q     <= prod3[Shift3 +: Q3W];
          q11_q    <= prod11[Shift11 +: Q11W];
        end
        REG_FLASH_MODE: mode_q  <= flash_mode_e'(cfg_ch_i.wdata[2:0]);
        REG_LED_COLOR:  color_q <= cfg_ch_i.wdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // Phase times: shifts and small adds on the stored quotients.
  assign q6      = q3_q[Q3W-1:1];
  assign t_half  = {1'b0, period_q[PeriodW-1:1]};
  assign t_third = PeriodW'(q3_q);
  assign t_sixth = PeriodW'(q6);
  assign t_elev  = PeriodW'(q11_q);
  assign t_two3  = {q3_q, 1'b0};
  assign t_five6 = PeriodW'({q6, 2'b00}) + PeriodW'(q6);
  assign t_ten11 = PeriodW'({q11_q, 3'b000}) + PeriodW'({q11_q, 1'b0});

  always_comb begin
    unique case (mode_q)
      MODE_HALF:          begin on_time = t_half;  off_time = t_half;  end
      MODE_THIRD:         begin on_time = t_third; off_time = t_two3;  end
      MODE_SIXTH:         begin on_time = t_sixth; off_time = t_five6; end
      MODE_ELEVENTH:      begin on_time = t_elev;  off_time = t_ten11; end
      MODE_TWO_THIRDS:    begin on_time = t_two3;  off_time = t_third; end
      MODE_FIVE_SIXTHS:   begin on_time = t_five6; off_time = t_sixth; end
      MODE_TEN_ELEVENTHS: begin on_time = t_ten11; off_time = t_elev;  end
      default:            begin on_time = period_q; off_time = period_q; end
    endcase
  end

  assign cfg_o.color    = color_q;
  assign cfg_o.mode     = mode_q;
  assign cfg_o.on_time  = on_time;
  assign cfg_o.off_time = off_time;

endmodule

[sv/rlbc_blink_core.sv]
// Blink state, millisecond countdown and registered LED result.
module rlbc_blink_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rlbc_pkg::cfg_t cfg_i,
  rlbc_in_if.sink        in_ch_i,
  rlbc_out_if.source     out_ch_o
);
  import rlbc_pkg::*;

  logic               lit_q, lit_d;
  logic [PeriodW-1:0] rem_q, rem_d, rem_sel;
  logic [MaskW-1:0]   mask_q, mask_d;
  logic               out_valid_q, out_valid_d;
  logic               in_ready, in_fire;

  // Take a new item whenever the result register is empty or being drained.
  assign in_ready      = !out_valid_q || out_ch_o.ready;
  assign in_fire       = in_ch_i.valid && in_ready;
  assign in_ch_i.ready = in_ready;

  always_comb begin
    lit_d   = lit_q;
    mask_d  = mask_q;
    rem_sel = rem_q;
    if (in_ch_i.card_seen) begin
      mask_d = MASK_GREEN;
    end else if (cfg_i.color == MASK_NONE) begin
      mask_d = MASK_NONE;
    end else if (cfg_i.mode == MODE_STEADY) begin
      mask_d = cfg_i.color;
    end else if (rem_q == '0) begin
      if (!lit_q) begin
        mask_d  = cfg_i.color;
        lit_d   = 1'b1;
        rem_sel = cfg_i.on_time;
      end else begin
        mask_d  = MASK_NONE;
        lit_d   = 1'b0;
        rem_sel = cfg_i.off_time;
      end
    end
    rem_d = (rem_sel == '0) ? '0 : rem_sel - 1'b1;
  end

  always_comb begin
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q       <= 1'b0;
      rem_q       <= '0;
      mask_q      <= MASK_NONE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        lit_q  <= lit_d;
        rem_q  <= rem_d;
        mask_q <= mask_d;
      end
    end
  end

  // The drive mask doubles as the result register: it moves only on an accepted item.
  assign out_ch_o.valid    = out_valid_q;
  assign out_ch_o.red_on   = mask_q[0];
  assign out_ch_o.green_on = mask_q[1];
  assign out_ch_o.blue_on  = mask_q[2];

endmodule

[sv/rgb_led_blink_controller.sv]
// Top level of the RGB LED blink controller.
//
//  channel    dir   handshake      payload
//  --------   ---   ------------   -----------------------------------
//  cfg_ch_i   in    valid/ready    index[1:0], wdata[15:0]
//  in_ch_i    in    valid/ready    card_seen
//  out_ch_o   out   valid/ready    red_on, green_on, blue_on
//
//  One item per clock cycle while the output takes results: each tick
//  is handled in the cycle it is accepted and its LED result sits in
//  the output register from the next. Configuration writes are always
//  accepted (ready is held high); the period quotients for the phase
//  times are taken from the write data. Reset loads the documented
//  register values, off phase, zero countdown and all LEDs dark; no
//  clearing pass is needed. A stalled output holds its item and input
//  ready drops only while the result register is full and not taken.
`include "rgb_led_blink_controller_assert.svh"

module rgb_led_blink_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlbc_cfg_if.sink    cfg_ch_i,
  rlbc_in_if.sink     in_ch_i,
  rlbc_out_if.source  out_ch_o
);
  import rlbc_pkg::*;

  cfg_t             cfg;
  logic             tick_fire;
  logic             card_tick;
  logic             plain_tick;
  logic             no_color;
  logic [MaskW-1:0] leds;

  // Registers, quotients and the on/off times for the selected ratio.
  rlbc_cfg_regs u_cfg_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_ch_i (cfg_ch_i),
    .cfg_o    (cfg)
  );

  // Phase state, countdown and the LED result register.
  rlbc_blink_core u_blink_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_ch_i  (in_ch_i),
    .out_ch_o (out_ch_o)
  );

  // Handshake and result views for the checks below.
  assign tick_fire  = in_ch_i.valid && in_ch_i.ready;
  assign card_tick  = tick_fire && in_ch_i.card_seen;
  assign plain_tick = tick_fire && !in_ch_i.card_seen;
  assign no_color   = (cfg.color == MASK_NONE);
  assign leds       = {out_ch_o.blue_on, out_ch_o.green_on, out_ch_o.red_on};

  // Every accepted tick leaves a result waiting in the next cycle.
  `RLBC_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, tick_fire, out_ch_o.valid)

  // A card-seen tick drives green alone.
  `RLBC_ASSERT_NEXT(a_card_forces_green, clk_i, rst_ni, card_tick, leds == MASK_GREEN)

  // With no colour set and no card, every LED goes dark.
  `RLBC_ASSERT_NEXT(a_none_is_dark, clk_i, rst_ni, plain_tick && no_color, leds == MASK_NONE)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the RGB LED blink controller: directed table, random phases.
module tb_top;
  import rlbc_pkg::*;

  // Clock, reset and run limits
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned RandomTicks  = 360;
  localparam int unsigned TailTicks    = 16;    // ticks run on after the long-period reload
  localparam int unsigned HoldOffAfter = 120;   // results seen before the long receiver stall
  localparam int unsigned HoldOffLen   = 150;   // cycles the receiver holds off for
  localparam int unsigned SettleCycles = 8;

  // Index with no register behind it: writes must be dropped by the block
  localparam logic [1:0] RegSpare = 2'd3;

  // LED masks used in the directed table (bit0 red, bit1 green, bit2 blue)
  localparam logic [MaskW-1:0] MaskRedBlue = 3'b101;
  localparam logic [MaskW-1:0] MaskAll     = 3'b111;

  logic clk;
  logic rst_n;

  rlbc_cfg_if cfg_ch ();
  rlbc_in_if  in_ch ();
  rlbc_out_if out_ch ();

  rgb_led_blink_controller uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_ch_i(cfg_ch.sink),
    .in_ch_i (in_ch.sink),
    .out_ch_o(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predicted block state and register copies. These mirror the block's view
  // of the world: the register copies change only on an accepted write, the
  // blink state only on an accepted tick.
  // ---------------------------------------------------------------------------
  logic [PeriodW-1:0] cfg_period = PERIOD_RESET;
  flash_mode_e        cfg_mode   = MODE_STEADY;
  logic [MaskW-1:0]   cfg_color  = MASK_NONE;

  bit                 pred_lit    = 1'b0;        // 1 while in the lit phase
  logic [PeriodW-1:0] pred_count  = '0;          // milliseconds left in the phase
  logic [MaskW-1:0]   pred_drive  = MASK_NONE;   // LED drive after the last tick
  int unsigned        pred_reloads = 0;          // phase flips seen so far

  // LED masks still owed by the block, oldest first
  logic [MaskW-1:0] pending_leds[$];

  int unsigned mismatch_count = 0;
  int unsigned leds_seen      = 0;
  int unsigned ticks_sent     = 0;
  int unsigned writes_done    = 0;
  int unsigned cycle_count    = 0;

  // Sender pacing state
  bit          tick_up    = 1'b0;   // in_ch.valid currently driven high
  bit          cfg_open   = 1'b0;   // cfg_ch.valid currently driven high
  int unsigned burst_left = 1;

  // Length of the phase that is about to start, truncating division throughout
  function automatic logic [PeriodW-1:0] phase_time(input bit lit_on);
    int unsigned p;
    int unsigned on_ms;
    int unsigned off_ms;
    p = cfg_period;
    case (cfg_mode)
      MODE_HALF:          begin on_ms = p / 2;             off_ms = p / 2;             end
      MODE_THIRD:         begin on_ms = p / 3;             off_ms = (p / 3) * 2;       end
      MODE_SIXTH:         begin on_ms = p / 6;             off_ms = (p / 6) * 5;       end
      MODE_ELEVENTH:      begin on_ms = p / 11;            off_ms = (p / 11) * 10;     end
      MODE_TWO_THIRDS:    begin on_ms = (p / 3) * 2;       off_ms = p / 3;             end
      MODE_FIVE_SIXTHS:   begin on_ms = (p / 6) * 5;       off_ms = p / 6;             end
      MODE_TEN_ELEVENTHS: begin on_ms = (p / 11) * 10;     off_ms = p / 11;            end
      default:            begin on_ms = p;                 off_ms = p;                 end
    endcase
    return lit_on ? PeriodW'(on_ms) : PeriodW'(off_ms);
  endfunction

  // Advance the blink state by one millisecond tick and return the LED drive
  task automatic predict_led_tick(input bit card, output logic [MaskW-1:0] drive);
    if (card) begin
      // card seen: green only, blink phase untouched
      pred_drive = MASK_GREEN;
    end else if (cfg_color == MASK_NONE) begin
      pred_drive = MASK_NONE;
    end else if (cfg_mode == MODE_STEADY) begin
      pred_drive = cfg_color;
    end else if (pred_count == '0) begin
      // phase expired: flip and reload, a zero length flips again next tick
      if (!pred_lit) begin
        pred_drive = cfg_color;
        pred_lit   = 1'b1;
        pred_count = phase_time(1'b1);
      end else begin
        pred_drive = MASK_NONE;
        pred_lit   = 1'b0;
        pred_count = phase_time(1'b0);
      end
      pred_reloads++;
    end
    // the countdown runs on every tick, after the decision
    if (pred_count != '0) pred_count = pred_count - 1'b1;
    drive = pred_drive;
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] LED mismatch at result %0d: %s", $time, leds_seen, what);
    mismatch_count++;
  endtask

  // Offer one tick; keep valid high afterwards unless the burst ends in a gap.
  // A typed expectation replaces the predicted one in the store, but the
  // prediction still runs so that the blink state stays in step.
  task automatic offer_tick(input bit card, input bit typed, input logic [MaskW-1:0] want);
    logic [MaskW-1:0] drive;
    int unsigned      gap;
    if (cfg_open) begin
      cfg_ch.valid <= 1'b0;
      cfg_open = 1'b0;
    end
    in_ch.valid     <= 1'b1;
    in_ch.card_seen <= card;
    tick_up = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_led_tick(card, drive);
    pending_leds.push_back(typed ? want : drive);
    ticks_sent++;
    // end of burst: drop valid for a random gap, sometimes none at all
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        tick_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Write one register once the block has drained every outstanding tick
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    if (tick_up) begin
      in_ch.valid <= 1'b0;
      tick_up = 1'b0;
    end
    while (pending_leds.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    cfg_open = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_FLASH_PERIOD: cfg_period = data;
      REG_FLASH_MODE:   cfg_mode   = flash_mode_e'(data[2:0]);
      REG_LED_COLOR:    cfg_color  = data[2:0];
      default: ;        // spare index: nothing changes
    endcase
    writes_done++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a typed expectation are the ones readable at a
  // glance (after reset, colour none, steady, zero period, card over blink);
  // the rest fall back on the prediction.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       idx;
    logic [15:0]      data;
    logic             card;
    logic             typed;
    logic [MaskW-1:0] want;
  } stim_row_t;

  localparam int unsigned DirectedLen = 32;

  localparam stim_row_t DirectedRows [DirectedLen] = '{
    // out of reset: colour none keeps all dark, card still lights green
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b1, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b1, 1'b1, MASK_GREEN},
    // steady red and blue
    '{ROW_WRITE, REG_LED_COLOR,    16'd5,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b1, MaskRedBlue},
    // zero period: the phase flips on every tick
    '{ROW_WRITE, REG_FLASH_MODE,   16'(MODE_HALF),         1'b0, 1'b0, MASK_NONE},
    '{ROW_WRITE, REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b1, MaskRedBlue},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b1, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b1, MaskRedBlue},
    // card in the lit phase: green, yet the lit phase is kept and ends next
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b1, 1'b1, MASK_GREEN},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b1, MASK_NONE},
    // longer lit phase; green left by a card holds while the phase runs
    '{ROW_WRITE, REG_FLASH_PERIOD, 16'd12,                 1'b0, 1'b0, MASK_NONE},
    '{ROW_WRITE, REG_FLASH_MODE,   16'(MODE_FIVE_SIXTHS),  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b1, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    // steady again, then colour none
    '{ROW_WRITE, REG_FLASH_MODE,   16'(MODE_STEADY),       1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b1, MaskRedBlue},
    '{ROW_WRITE, REG_LED_COLOR,    16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b1, MASK_NONE},
    // all colours, third duty, plus a write to the spare index
    '{ROW_WRITE, REG_LED_COLOR,    16'(MaskAll),           1'b0, 1'b0, MASK_NONE},
    '{ROW_WRITE, REG_FLASH_PERIOD, 16'd3,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_WRITE, REG_FLASH_MODE,   16'(MODE_THIRD),        1'b0, 1'b0, MASK_NONE},
    '{ROW_WRITE, RegSpare,         16'hFFFF,               1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE},
    '{ROW_TICK,  REG_FLASH_PERIOD, 16'd0,                  1'b0, 1'b0, MASK_NONE}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned      n;
    int unsigned      random_ticks;
    int unsigned      directed_ticks;
    int unsigned      reloads_at_start;
    flash_mode_e      mode;
    logic [MaskW-1:0] color;

    rst_n           <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.wdata    <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.card_seen <= 1'b0;
    random_ticks    = 0;
    burst_left      = $urandom_range(1, 24);

    // hold reset, then release it on an edge
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (int i = 0; i < DirectedLen; i++) begin
      if (DirectedRows[i].kind == ROW_WRITE)
        write_reg(DirectedRows[i].idx, DirectedRows[i].data);
      else
        offer_tick(DirectedRows[i].card, DirectedRows[i].typed, DirectedRows[i].want);
    end
    directed_ticks = ticks_sent;

    // Random phases: a full-range period write first so every data bit moves,
    // then a short period wherever blinking is live so phases flip often.
    // Mode and colour writes carry junk in the unused upper data bits.
    while (random_ticks < RandomTicks) begin
      write_reg(REG_FLASH_PERIOD, 16'($urandom_range(0, 65535)));
      mode  = flash_mode_e'(3'($urandom_range(0, 7)));
      color = ($urandom_range(0, 5) == 0) ? MASK_NONE : MaskW'($urandom_range(1, 7));
      write_reg(REG_FLASH_MODE, {13'($urandom), mode});
      write_reg(REG_LED_COLOR,  {13'($urandom), color});
      if (mode != MODE_STEADY && color != MASK_NONE)
        write_reg(REG_FLASH_PERIOD, ($urandom_range(0, 3) == 0) ?
                  16'($urandom_range(0, 3)) : 16'($urandom_range(4, 40)));
      if ($urandom_range(0, 4) == 0) write_reg(RegSpare, 16'($urandom));
      n = $urandom_range(5, 40);
      repeat (n) begin
        offer_tick($urandom_range(0, 7) == 0, 1'b0, MASK_NONE);
        random_ticks++;
      end
    end

    // Longest period: pick the mode so that the next phase is the short one
    // (65535/11 ms), run until it has been loaded, then a few ticks into it.
    write_reg(REG_FLASH_PERIOD, 16'hFFFF);
    write_reg(REG_FLASH_MODE, 16'(pred_lit ? MODE_TEN_ELEVENTHS : MODE_ELEVENTH));
    write_reg(REG_LED_COLOR, 16'(MaskAll));
    reloads_at_start = pred_reloads;
    do
      offer_tick($urandom_range(0, 7) == 0, 1'b0, MASK_NONE);
    while (pred_reloads == reloads_at_start);
    repeat (TailTicks) offer_tick($urandom_range(0, 7) == 0, 1'b0, MASK_NONE);

    // drain, settle, report
    if (tick_up) in_ch.valid <= 1'b0;
    if (cfg_open) cfg_ch.valid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Covered %0d ticks (%0d from the table), %0d register writes and %0d phase flips,",
             ticks_sent, directed_ticks, writes_done, pred_reloads);
    $display("every duty mode and colour, zero and 65535 ms periods; %0d results checked.",
             leds_seen);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready runs of random length broken by short stalls, plus one
  // long hold-off once traffic is flowing so the result register fills and
  // the block has to push back on its input.
  // ---------------------------------------------------------------------------
  initial begin
    bit          held_off;
    int unsigned run_len;
    int unsigned stall_len;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if (!held_off && leds_seen >= HoldOffAfter) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk);
      end
      run_len = $urandom_range(1, 30);
      out_ch.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if (stall_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Result checker: compare each accepted result with the oldest expectation
  logic [MaskW-1:0] want_leds;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      leds_seen++;
      if (pending_leds.size() == 0) begin
        flag_mismatch("result arrived with nothing outstanding");
      end else begin
        want_leds = pending_leds.pop_front();
        if (out_ch.red_on !== want_leds[0])
          flag_mismatch($sformatf("red_on %b, want %b", out_ch.red_on, want_leds[0]));
        if (out_ch.green_on !== want_leds[1])
          flag_mismatch($sformatf("green_on %b, want %b", out_ch.green_on, want_leds[1]));
        if (out_ch.blue_on !== want_leds[2])
          flag_mismatch($sformatf("blue_on %b, want %b", out_ch.blue_on, want_leds[2]));
      end
    end
  end

  // Watchdog: drop out if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_leds.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
